@@ rtl/pmds_pkg.sv @@
// Shared types, constants and the control program of the pen stroke filter.
`default_nettype none

package pmds_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int K_W            = 24;
	localparam int W_W            = 26;
	localparam int OFF_W          = 25;
	localparam int OUT_W          = 32;
	localparam int CMD_W          = 3;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 26;
	localparam int PC_W           = 6;
	localparam int PROG_LEN       = 33;

	localparam logic [K_W-1:0] MASS_RST   = 24'd8389;
	localparam logic [K_W-1:0] DAMP_RST   = 24'd16642998;
	localparam logic [W_W-1:0] WIDTH_RST  = 26'd6291456;
	localparam logic [K_W-1:0] SIN60_Q24  = 24'd7264748;
	localparam logic [K_W-1:0] Q24_HALF   = 24'd8388608;

	localparam logic [CMD_W-1:0] CMD_DOWN = 3'd0;
	localparam logic [CMD_W-1:0] CMD_MOVE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TICK = 3'd2;
	localparam logic [CMD_W-1:0] CMD_EMIT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_UP   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_MASS_RECIP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DAMPING      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STROKE_WIDTH = 2'd2;

	localparam logic AX_X = 1'b0;
	localparam logic AX_Y = 1'b1;

	typedef enum logic [3:0] {
		OP_NOP, OP_PEN_DOWN, OP_PEN_UP, OP_SET_TGT,
		OP_LD_DIFF, OP_LD_VEL, OP_LD_WPREV, OP_LD_WCUR,
		OP_MUL_LO, OP_MUL_HI, OP_VEL_ADD, OP_VEL_MUL,
		OP_POS_ADD, OP_ST_LOFF, OP_ST_COFF, OP_CORNERS
	} op_t;

	typedef enum logic [1:0] {K_MASS, K_DAMP, K_SIN} ksel_t;

	typedef enum logic [1:0] {J_NEXT, J_ALWAYS, J_IF_SAME, J_IF_IDLE} jmp_t;

	typedef struct packed {
		op_t             op;
		logic            axis;
		ksel_t           ksel;
		jmp_t            jmp;
		logic [PC_W-1:0] tgt;
		logic            last;
	} ctl_t;

	typedef struct packed {
		ctl_t cw;
		logic take;
		logic fire;
	} seq_ctl_t;

	typedef struct packed {
		logic same;
		logic active;
	} stat_t;

	typedef struct packed {
		logic                  seg;
		logic [7:0][OUT_W-1:0] cor;
		logic                  act;
	} res_t;

	// program entry points
	localparam logic [PC_W-1:0] A_FIN  = 6'd0;
	localparam logic [PC_W-1:0] A_DOWN = 6'd1;
	localparam logic [PC_W-1:0] A_UP   = 6'd2;
	localparam logic [PC_W-1:0] A_MOVE = 6'd3;
	localparam logic [PC_W-1:0] A_TICK = 6'd4;
	localparam logic [PC_W-1:0] A_STEP = 6'd5;
	localparam logic [PC_W-1:0] A_EMIT = 6'd23;

	function automatic ctl_t mk(input op_t op, input logic axis, input ksel_t ksel,
		input jmp_t jmp, input logic [PC_W-1:0] tgt, input logic last);
		ctl_t c;
		c.op   = op;
		c.axis = axis;
		c.ksel = ksel;
		c.jmp  = jmp;
		c.tgt  = tgt;
		c.last = last;
		return c;
	endfunction

	localparam ctl_t CW_IDLE = mk(OP_NOP, AX_X, K_MASS, J_NEXT, A_FIN, 1'b0);

	localparam ctl_t PROG [PROG_LEN] = '{
		mk(OP_NOP,      AX_X, K_MASS, J_NEXT,    A_FIN,  1'b1),
		mk(OP_PEN_DOWN, AX_X, K_MASS, J_ALWAYS,  A_FIN,  1'b0),
		mk(OP_PEN_UP,   AX_X, K_MASS, J_ALWAYS,  A_FIN,  1'b0),
		mk(OP_SET_TGT,  AX_X, K_MASS, J_ALWAYS,  A_STEP, 1'b0),
		mk(OP_NOP,      AX_X, K_MASS, J_IF_IDLE, A_FIN,  1'b0),
		// filter step, x axis
		mk(OP_LD_DIFF,  AX_X, K_MASS, J_NEXT,    A_FIN,  1'b0),
		mk(OP_MUL_LO,   AX_X, K_MASS, J_NEXT,    A_FIN,  1'b0),
		mk(OP_MUL_HI,   AX_X, K_MASS, J_NEXT,    A_FIN,  1'b0),
		mk(OP_VEL_ADD,  AX_X, K_MASS, J_NEXT,    A_FIN,  1'b0),
		mk(OP_LD_VEL,   AX_X, K_DAMP, J_NEXT,    A_FIN,  1'b0),
		mk(OP_MUL_LO,   AX_X, K_DAMP, J_NEXT,    A_FIN,  1'b0),
		mk(OP_MUL_HI,   AX_X, K_DAMP, J_NEXT,    A_FIN,  1'b0),
		mk(OP_VEL_MUL,  AX_X, K_DAMP, J_NEXT,    A_FIN,  1'b0),
		mk(OP_POS_ADD,  AX_X, K_DAMP, J_NEXT,    A_FIN,  1'b0),
		// filter step, y axis
		mk(OP_LD_DIFF,  AX_Y, K_MASS, J_NEXT,    A_FIN,  1'b0),
		mk(OP_MUL_LO,   AX_Y, K_MASS, J_NEXT,    A_FIN,  1'b0),
		mk(OP_MUL_HI,   AX_Y, K_MASS, J_NEXT,    A_FIN,  1'b0),
		mk(OP_VEL_ADD,  AX_Y, K_MASS, J_NEXT,    A_FIN,  1'b0),
		mk(OP_LD_VEL,   AX_Y, K_DAMP, J_NEXT,    A_FIN,  1'b0),
		mk(OP_MUL_LO,   AX_Y, K_DAMP, J_NEXT,    A_FIN,  1'b0),
		mk(OP_MUL_HI,   AX_Y, K_DAMP, J_NEXT,    A_FIN,  1'b0),
		mk(OP_VEL_MUL,  AX_Y, K_DAMP, J_NEXT,    A_FIN,  1'b0),
		mk(OP_POS_ADD,  AX_Y, K_DAMP, J_ALWAYS,  A_FIN,  1'b0),
		// emit
		mk(OP_NOP,      AX_X, K_SIN,  J_IF_SAME, A_FIN,  1'b0),
		mk(OP_LD_WPREV, AX_X, K_SIN,  J_NEXT,    A_FIN,  1'b0),
		mk(OP_MUL_LO,   AX_X, K_SIN,  J_NEXT,    A_FIN,  1'b0),
		mk(OP_MUL_HI,   AX_X, K_SIN,  J_NEXT,    A_FIN,  1'b0),
		mk(OP_ST_LOFF,  AX_X, K_SIN,  J_NEXT,    A_FIN,  1'b0),
		mk(OP_LD_WCUR,  AX_X, K_SIN,  J_NEXT,    A_FIN,  1'b0),
		mk(OP_MUL_LO,   AX_X, K_SIN,  J_NEXT,    A_FIN,  1'b0),
		mk(OP_MUL_HI,   AX_X, K_SIN,  J_NEXT,    A_FIN,  1'b0),
		mk(OP_ST_COFF,  AX_X, K_SIN,  J_NEXT,    A_FIN,  1'b0),
		mk(OP_CORNERS,  AX_X, K_SIN,  J_ALWAYS,  A_FIN,  1'b0)
	};

	function automatic ctl_t rom(input logic [PC_W-1:0] a);
		if (a < PC_W'(PROG_LEN))
			return PROG[a];
		return PROG[A_FIN];
	endfunction

	function automatic logic [PC_W-1:0] entry(input logic [CMD_W-1:0] c);
		logic [PC_W-1:0] a;
		case (c)
			CMD_DOWN: a = A_DOWN;
			CMD_MOVE: a = A_MOVE;
			CMD_TICK: a = A_TICK;
			CMD_EMIT: a = A_EMIT;
			CMD_UP:   a = A_UP;
			default:  a = A_FIN;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

@@ rtl/pmds_if.sv @@
// Channel interfaces: pen events in, stroke segments out, register writes.
`default_nettype none

interface pmds_pen_if;
	logic                            valid;
	logic                            ready;
	logic [pmds_pkg::CMD_W-1:0]      cmd;
	logic signed [pmds_pkg::OUT_W-1:0] point_x;
	logic signed [pmds_pkg::OUT_W-1:0] point_y;
	modport source (output valid, cmd, point_x, point_y, input ready);
	modport sink (input valid, cmd, point_x, point_y, output ready);
endinterface

interface pmds_seg_if;
	logic                              valid;
	logic                              ready;
	logic                              segment_valid;
	logic signed [pmds_pkg::OUT_W-1:0] corner0_x;
	logic signed [pmds_pkg::OUT_W-1:0] corner0_y;
	logic signed [pmds_pkg::OUT_W-1:0] corner1_x;
	logic signed [pmds_pkg::OUT_W-1:0] corner1_y;
	logic signed [pmds_pkg::OUT_W-1:0] corner2_x;
	logic signed [pmds_pkg::OUT_W-1:0] corner2_y;
	logic signed [pmds_pkg::OUT_W-1:0] corner3_x;
	logic signed [pmds_pkg::OUT_W-1:0] corner3_y;
	logic                              pen_active;
	modport source (output valid, segment_valid, corner0_x, corner0_y, corner1_x,
		corner1_y, corner2_x, corner2_y, corner3_x, corner3_y, pen_active, input ready);
	modport sink (input valid, segment_valid, corner0_x, corner0_y, corner1_x,
		corner1_y, corner2_x, corner2_y, corner3_x, corner3_y, pen_active, output ready);
endinterface

interface pmds_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [pmds_pkg::CFG_IDX_W-1:0]      index;
	logic [pmds_pkg::CFG_DATA_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/pmds_seq.sv @@
// Microcode sequencer: step counter, program ROM, jumps and result handshake.
`default_nettype none

module pmds_seq (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [pmds_pkg::CMD_W-1:0] in_cmd,
	output logic                            in_ready,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	input  wire pmds_pkg::stat_t            st,
	output pmds_pkg::seq_ctl_t              sc
);

	logic                      busy_q;
	logic [pmds_pkg::PC_W-1:0] pc_q;
	logic                      out_valid_q;
	pmds_pkg::ctl_t            cw;
	logic                      stall;
	logic                      run;
	logic                      jump;

	always_comb begin
		cw    = pmds_pkg::rom(pc_q);
		stall = cw.last && out_valid_q && !out_ready;
		run   = busy_q && !stall;
		unique case (cw.jmp)
			pmds_pkg::J_NEXT:    jump = 1'b0;
			pmds_pkg::J_ALWAYS:  jump = 1'b1;
			pmds_pkg::J_IF_SAME: jump = st.same;
			pmds_pkg::J_IF_IDLE: jump = !st.active;
			default:             jump = 1'b0;
		endcase
		sc.cw   = run ? cw : pmds_pkg::CW_IDLE;
		sc.take = in_valid && !busy_q;
		sc.fire = run && cw.last;
	end

	assign in_ready  = !busy_q;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= pmds_pkg::A_FIN;
			out_valid_q <= 1'b0;
		end else begin
			if (sc.take) begin
				busy_q <= 1'b1;
				pc_q   <= pmds_pkg::entry(in_cmd);
			end else if (run) begin
				if (cw.last)
					busy_q <= 1'b0;
				pc_q <= jump ? cw.tgt : pc_q + pmds_pkg::PC_W'(1);
			end
			if (sc.fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	a_fire_slot: assert property (@(posedge clk) disable iff (!arst_n)
		sc.fire |-> (!out_valid_q || out_ready))
		else $error("result written while output slot still full");

	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(sc.fire))
		else $error("sequencer went idle without delivering a result");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pc_q < pmds_pkg::PC_W'(pmds_pkg::PROG_LEN)))
		else $error("step counter outside the program");

	a_fire_valid: assert property (@(posedge clk) disable iff (!arst_n)
		sc.fire |=> out_valid_q)
		else $error("finished result not presented");

endmodule

`default_nettype wire

@@ rtl/pmds_dp.sv @@
// Datapath: filter state, shared 24x24 multiplier, offsets, corners, registers.
`default_nettype none

module pmds_dp #(
	parameter int COORD_BITS = pmds_pkg::COORD_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	pmds_cfg_if.sink                        cfg,
	input  wire pmds_pkg::seq_ctl_t         sc,
	input  wire logic [pmds_pkg::OUT_W-1:0] pt_x,
	input  wire logic [pmds_pkg::OUT_W-1:0] pt_y,
	output pmds_pkg::stat_t                 st,
	output pmds_pkg::res_t                  res
);

	localparam int CB    = COORD_BITS;
	localparam int KW    = pmds_pkg::K_W;
	localparam int HI_W  = (CB > 26) ? CB - KW : 2;
	localparam int EXT_W = KW + HI_W;
	localparam int ACC_W = EXT_W + KW;
	localparam int IN_W  = (CB > 32) ? CB : 32;
	localparam int SW    = EXT_W + 1;
	localparam int WW    = (SW > 33) ? SW : 33;
	localparam int OW    = pmds_pkg::OFF_W;
	localparam int WDW   = pmds_pkg::W_W;
	localparam int OUTW  = pmds_pkg::OUT_W;

	function automatic logic [CB-1:0] sat_cb(input logic [CB+1:0] s);
		if (&s[CB+1:CB-1] || ~|s[CB+1:CB-1])
			return s[CB-1:0];
		return s[CB+1] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
	endfunction

	function automatic logic [CB-1:0] sat_in(input logic [OUTW-1:0] p);
		logic [IN_W-1:0] w;
		w = IN_W'($signed(p));
		if (&w[IN_W-1:CB-1] || ~|w[IN_W-1:CB-1])
			return w[CB-1:0];
		return w[IN_W-1] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
	endfunction

	function automatic logic [OW-1:0] off_x(input logic [WDW-1:0] w);
		logic [WDW:0] s;
		s = (WDW+1)'(w) + (WDW+1)'(2);
		return s[WDW:2];
	endfunction

	function automatic logic [OUTW-1:0] corner(input logic [CB-1:0] p,
		input logic [OW-1:0] o, input logic sub);
		logic [SW-1:0] pe;
		logic [SW-1:0] oe;
		logic [SW-1:0] s;
		logic [WW-1:0] w;
		pe = SW'($signed(p));
		oe = SW'(o);
		s  = sub ? pe - oe : pe + oe;
		w  = WW'($signed(s));
		if (&w[WW-1:OUTW-1] || ~|w[WW-1:OUTW-1])
			return w[OUTW-1:0];
		return w[WW-1] ? {1'b1, {(OUTW-1){1'b0}}} : {1'b0, {(OUTW-1){1'b1}}};
	endfunction

	logic [CB-1:0]     tgt_q [2];
	logic [CB-1:0]     pos_q [2];
	logic [CB-1:0]     vel_q [2];
	logic [CB-1:0]     drw_q [2];
	logic [CB-1:0]     pt_q [2];
	logic [WDW-1:0]    wprev_q;
	logic              act_q;
	logic              seg_q;
	logic [KW-1:0]     mass_q;
	logic [KW-1:0]     damp_q;
	logic [WDW-1:0]    width_q;
	logic [EXT_W-1:0]  mag_q;
	logic              neg_q;
	logic [ACC_W-1:0]  acc_q;
	logic [OW-1:0]     loff_x_q, loff_y_q, coff_x_q, coff_y_q;
	logic [7:0][OUTW-1:0] cor_q;
	pmds_pkg::res_t    res_q;

	logic              ax;
	logic [CB:0]       d;
	logic [CB-1:0]     dmag;
	logic [CB:0]       ve;
	logic [CB-1:0]     vmag;
	logic [KW-1:0]     k;
	logic [KW-1:0]     mop;
	logic [2*KW-1:0]   prod;
	logic [CB:0]       rr;
	logic [CB:0]       sr;
	logic [CB+1:0]     vsum;
	logic [CB+1:0]     psum;

	always_comb begin
		ax   = sc.cw.axis;
		d    = {tgt_q[ax][CB-1], tgt_q[ax]} - {pos_q[ax][CB-1], pos_q[ax]};
		dmag = d[CB] ? CB'(-d) : CB'(d);
		ve   = {vel_q[ax][CB-1], vel_q[ax]};
		vmag = ve[CB] ? CB'(-ve) : CB'(ve);
		case (sc.cw.ksel)
			pmds_pkg::K_MASS: k = mass_q;
			pmds_pkg::K_DAMP: k = damp_q;
			pmds_pkg::K_SIN:  k = pmds_pkg::SIN60_Q24;
			default:          k = '0;
		endcase
		mop  = (sc.cw.op == pmds_pkg::OP_MUL_HI) ? KW'(mag_q[EXT_W-1:KW]) : mag_q[KW-1:0];
		prod = (2*KW)'(mop) * (2*KW)'(k);
		rr   = {1'b0, acc_q[KW +: CB]};
		sr   = neg_q ? -rr : rr;
		vsum = {{2{vel_q[ax][CB-1]}}, vel_q[ax]} + {sr[CB], sr};
		psum = {{2{pos_q[ax][CB-1]}}, pos_q[ax]} + {{2{vel_q[ax][CB-1]}}, vel_q[ax]};
	end

	assign cfg.ready = 1'b1;
	assign st.same   = (pos_q[0] == drw_q[0]) && (pos_q[1] == drw_q[1]);
	assign st.active = act_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q   <= '{default: '0};
			pos_q   <= '{default: '0};
			vel_q   <= '{default: '0};
			drw_q   <= '{default: '0};
			wprev_q <= pmds_pkg::WIDTH_RST;
			act_q   <= 1'b0;
			seg_q   <= 1'b0;
			mass_q  <= pmds_pkg::MASS_RST;
			damp_q  <= pmds_pkg::DAMP_RST;
			width_q <= pmds_pkg::WIDTH_RST;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					pmds_pkg::CFG_MASS_RECIP:   mass_q  <= cfg.data[KW-1:0];
					pmds_pkg::CFG_DAMPING:      damp_q  <= cfg.data[KW-1:0];
					pmds_pkg::CFG_STROKE_WIDTH: width_q <= cfg.data[WDW-1:0];
					default: ;
				endcase
			end
			if (sc.take)
				seg_q <= 1'b0;
			unique case (sc.cw.op)
				pmds_pkg::OP_PEN_DOWN: begin
					tgt_q <= pt_q;
					pos_q <= pt_q;
					drw_q <= pt_q;
					vel_q <= '{default: '0};
					act_q <= 1'b1;
				end
				pmds_pkg::OP_PEN_UP:  act_q <= 1'b0;
				pmds_pkg::OP_SET_TGT: tgt_q <= pt_q;
				pmds_pkg::OP_VEL_ADD: vel_q[ax] <= sat_cb(vsum);
				pmds_pkg::OP_VEL_MUL: vel_q[ax] <= sr[CB-1:0];
				pmds_pkg::OP_POS_ADD: pos_q[ax] <= sat_cb(psum);
				pmds_pkg::OP_CORNERS: begin
					seg_q   <= 1'b1;
					wprev_q <= width_q;
					drw_q   <= pos_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sc.take) begin
			pt_q[0] <= sat_in(pt_x);
			pt_q[1] <= sat_in(pt_y);
		end
		case (sc.cw.op)
			pmds_pkg::OP_LD_DIFF: begin
				mag_q <= EXT_W'(dmag);
				neg_q <= d[CB];
			end
			pmds_pkg::OP_LD_VEL: begin
				mag_q <= EXT_W'(vmag);
				neg_q <= ve[CB];
			end
			pmds_pkg::OP_LD_WPREV: begin
				mag_q <= EXT_W'(wprev_q);
				neg_q <= 1'b0;
			end
			pmds_pkg::OP_LD_WCUR: begin
				mag_q <= EXT_W'(width_q);
				neg_q <= 1'b0;
			end
			pmds_pkg::OP_MUL_LO: acc_q <= ACC_W'(prod) + ACC_W'(pmds_pkg::Q24_HALF);
			pmds_pkg::OP_MUL_HI: acc_q <= acc_q + (ACC_W'(prod) << KW);
			pmds_pkg::OP_ST_LOFF: begin
				loff_x_q <= off_x(wprev_q);
				loff_y_q <= acc_q[KW +: OW];
			end
			pmds_pkg::OP_ST_COFF: begin
				coff_x_q <= off_x(width_q);
				coff_y_q <= acc_q[KW +: OW];
			end
			pmds_pkg::OP_CORNERS: begin
				cor_q[0] <= corner(drw_q[0], loff_x_q, 1'b1);
				cor_q[1] <= corner(drw_q[1], loff_y_q, 1'b1);
				cor_q[2] <= corner(pos_q[0], coff_x_q, 1'b1);
				cor_q[3] <= corner(pos_q[1], coff_y_q, 1'b1);
				cor_q[4] <= corner(pos_q[0], coff_x_q, 1'b0);
				cor_q[5] <= corner(pos_q[1], coff_y_q, 1'b0);
				cor_q[6] <= corner(drw_q[0], loff_x_q, 1'b0);
				cor_q[7] <= corner(drw_q[1], loff_y_q, 1'b0);
			end
			default: ;
		endcase
		if (sc.fire) begin
			res_q.seg <= seg_q;
			res_q.cor <= seg_q ? cor_q : '0;
			res_q.act <= act_q;
		end
	end

endmodule

`default_nettype wire

@@ rtl/pen_mass_drag_stroke_filter.sv @@
// Top level of the pen mass-drag stroke filter.
//
//   channel  | role   | payload
//   ---------+--------+-----------------------------------------------------
//   pen      | sink   | cmd, point_x, point_y
//   stroke   | source | segment_valid, corner0..3_x/y, pen_active
//   cfg      | sink   | index (0 mass_recip, 1 damping, 2 stroke_width), data
//
// One item at a time: the next pen event is taken only once the program of the last has run.
// The single shared 24x24 multiplier runs two partial products for each of the four
// scalings in a filter step.
// The result sits in an output register; the next item is taken meanwhile.
// Reset is asynchronous; cfg writes are taken on every cycle.
`default_nettype none

module pen_mass_drag_stroke_filter #(
	parameter int COORD_BITS = pmds_pkg::COORD_BITS_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	pmds_pen_if.sink    pen,
	pmds_seg_if.source  stroke,
	pmds_cfg_if.sink    cfg
);

	pmds_pkg::seq_ctl_t sc;
	pmds_pkg::stat_t    st;
	pmds_pkg::res_t     res;

	pmds_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pen.valid),
		.in_cmd    (pen.cmd),
		.in_ready  (pen.ready),
		.out_valid (stroke.valid),
		.out_ready (stroke.ready),
		.st        (st),
		.sc        (sc)
	);

	pmds_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.sc     (sc),
		.pt_x   (pen.point_x),
		.pt_y   (pen.point_y),
		.st     (st),
		.res    (res)
	);

	assign stroke.segment_valid = res.seg;
	assign stroke.corner0_x     = res.cor[0];
	assign stroke.corner0_y     = res.cor[1];
	assign stroke.corner1_x     = res.cor[2];
	assign stroke.corner1_y     = res.cor[3];
	assign stroke.corner2_x     = res.cor[4];
	assign stroke.corner2_y     = res.cor[5];
	assign stroke.corner3_x     = res.cor[6];
	assign stroke.corner3_y     = res.cor[7];
	assign stroke.pen_active    = res.act;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench of the pen stroke filter: event stimulus in register phases, predictor, checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pmds_pkg::*;

	localparam int     RST_CYCLES   = 8;
	localparam int     CYCLE_LIMIT  = 600000;
	localparam int     DRAIN_CYCLES = 30;
	localparam int     PHASE_ITEMS  = 165;
	localparam int     RAND_PHASES  = 8;
	localparam int     MAX_REPORTS  = 10;
	localparam int     HOLD_CYCLES  = 600;
	localparam longint C_MAX        = 64'sd2147483647;
	localparam longint C_MIN        = -64'sd2147483648;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [CMD_W-1:0]     CMD_RSVD5  = 3'd5;
	localparam logic [CMD_W-1:0]     CMD_RSVD6  = 3'd6;
	localparam logic [CMD_W-1:0]     CMD_RSVD7  = 3'd7;

	typedef struct packed {
		logic [CMD_W-1:0]        cmd;
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
	} pen_evt_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_COMB, RX_SPARSE} rx_mode_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                    pen_vld = 1'b0;
	logic [CMD_W-1:0]        pen_cmd = '0;
	logic [OUT_W-1:0]        pen_x   = '0;
	logic [OUT_W-1:0]        pen_y   = '0;
	logic                    rcv_rdy = 1'b0;
	logic                    cfg_vld = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_idx = '0;
	logic [CFG_DATA_W-1:0]   cfg_dat = '0;

	pmds_pen_if pen_ch ();
	pmds_seg_if seg_ch ();
	pmds_cfg_if cfg_ch ();

	assign pen_ch.valid   = pen_vld;
	assign pen_ch.cmd     = pen_cmd;
	assign pen_ch.point_x = pen_x;
	assign pen_ch.point_y = pen_y;
	assign seg_ch.ready   = rcv_rdy;
	assign cfg_ch.valid   = cfg_vld;
	assign cfg_ch.index   = cfg_idx;
	assign cfg_ch.data    = cfg_dat;

	pen_mass_drag_stroke_filter uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pen    (pen_ch),
		.stroke (seg_ch),
		.cfg    (cfg_ch)
	);

	initial forever #10 clk = ~clk;

	pen_evt_t event_q [$];
	res_t     stroke_q [$];
	int       fail_count = 0;

	// predictor state
	logic [K_W-1:0] mass_k, damp_k;
	logic [W_W-1:0] width_cur, width_prior;
	longint         tgt_x, tgt_y, pos_x, pos_y, vel_x, vel_y, drawn_x, drawn_y;
	logic           pen_dn;

	function automatic void reset_model();
		mass_k      = MASS_RST;
		damp_k      = DAMP_RST;
		width_cur   = WIDTH_RST;
		width_prior = WIDTH_RST;
		tgt_x = 0; tgt_y = 0; pos_x = 0; pos_y = 0;
		vel_x = 0; vel_y = 0; drawn_x = 0; drawn_y = 0;
		pen_dn = 1'b0;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > C_MAX)
			return C_MAX;
		if (v < C_MIN)
			return C_MIN;
		return v;
	endfunction

	// Q0.24 scaling, round to nearest, ties away from zero
	function automatic longint scale_q24(longint v, logic [K_W-1:0] k);
		longint unsigned mag, hi, lo, r;
		mag = (v < 0) ? -v : v;
		hi  = mag >> 24;
		lo  = mag & 64'hFF_FFFF;
		r   = hi * k + ((lo * k + Q24_HALF) >> 24);
		return (v < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic void filter_step();
		longint ax, ay;
		ax    = scale_q24(tgt_x - pos_x, mass_k);
		ay    = scale_q24(tgt_y - pos_y, mass_k);
		vel_x = scale_q24(clamp32(vel_x + ax), damp_k);
		vel_y = scale_q24(clamp32(vel_y + ay), damp_k);
		pos_x = clamp32(pos_x + vel_x);
		pos_y = clamp32(pos_y + vel_y);
	endfunction

	function automatic longint half_dx(logic [W_W-1:0] w);
		return (longint'(w) + 2) >>> 2;
	endfunction

	function automatic longint half_dy(logic [W_W-1:0] w);
		return (longint'(w) * longint'(SIN60_Q24) + longint'(Q24_HALF)) >>> 24;
	endfunction

	function automatic res_t filter_event(pen_evt_t e);
		res_t   r;
		longint px, py, lx, ly, cx, cy;
		r  = '0;
		px = longint'(e.x);
		py = longint'(e.y);
		case (e.cmd)
			CMD_DOWN: begin
				tgt_x = px; pos_x = px; drawn_x = px;
				tgt_y = py; pos_y = py; drawn_y = py;
				vel_x = 0; vel_y = 0;
				pen_dn = 1'b1;
			end
			CMD_MOVE: begin
				tgt_x = px;
				tgt_y = py;
				filter_step();
			end
			CMD_TICK: begin
				if (pen_dn)
					filter_step();
			end
			CMD_EMIT: begin
				if (pos_x != drawn_x || pos_y != drawn_y) begin
					lx = half_dx(width_prior);
					ly = half_dy(width_prior);
					cx = half_dx(width_cur);
					cy = half_dy(width_cur);
					r.seg    = 1'b1;
					r.cor[0] = OUT_W'(clamp32(drawn_x - lx));
					r.cor[1] = OUT_W'(clamp32(drawn_y - ly));
					r.cor[2] = OUT_W'(clamp32(pos_x - cx));
					r.cor[3] = OUT_W'(clamp32(pos_y - cy));
					r.cor[4] = OUT_W'(clamp32(pos_x + cx));
					r.cor[5] = OUT_W'(clamp32(pos_y + cy));
					r.cor[6] = OUT_W'(clamp32(drawn_x + lx));
					r.cor[7] = OUT_W'(clamp32(drawn_y + ly));
					width_prior = width_cur;
					drawn_x = pos_x;
					drawn_y = pos_y;
				end
			end
			CMD_UP: pen_dn = 1'b0;
			default: ;
		endcase
		r.act = pen_dn;
		return r;
	endfunction

	// driver: bursts with random gaps
	pen_evt_t cur_evt;
	int       burst_left = 1;
	int       gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		logic nxt_vld;
		if (!arst_n) begin
			pen_vld <= 1'b0;
			burst_left = 1;
			gap_left   = 0;
		end else begin
			nxt_vld = pen_vld;
			if (pen_vld && pen_ch.ready) begin
				stroke_q.push_back(filter_event(cur_evt));
				nxt_vld = 1'b0;
			end
			if (!nxt_vld) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (event_q.size() != 0) begin
					cur_evt = event_q.pop_front();
					pen_cmd <= cur_evt.cmd;
					pen_x   <= cur_evt.x;
					pen_y   <= cur_evt.y;
					nxt_vld = 1'b1;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 50);
						gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40)
							: $urandom_range(0, 3);
					end
				end
			end
			pen_vld <= nxt_vld;
		end
	end

	// long receiver hold-off and cycle limit
	int cyc        = 0;
	int hold_left  = 0;
	int holds_done = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc        <= 0;
			hold_left  <= 0;
			holds_done <= 0;
		end else begin
			cyc <= cyc + 1;
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end else if (holds_done < 2 && pen_vld
				&& cyc >= ((holds_done == 0) ? 1500 : 7000)) begin
				hold_left  <= HOLD_CYCLES;
				holds_done <= holds_done + 1;
			end
			if (cyc >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cyc);
				$display("[pen_mass_drag_stroke_filter] ERROR");
				$finish;
			end
		end
	end

	task automatic check_field(input string name, input logic [OUT_W-1:0] want,
		input logic [OUT_W-1:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("mismatch %s: expected %h, got %h", name, want, got);
		end
	endtask

	// monitor and receiver stall pattern
	rx_mode_t rcv_mode  = RX_OPEN;
	int       rcv_win   = 0;
	int       rcv_phase = 0;

	always @(posedge clk or negedge arst_n) begin
		res_t got, want;
		logic nxt_rdy;
		if (!arst_n) begin
			rcv_rdy <= 1'b0;
			rcv_mode  = RX_OPEN;
			rcv_win   = 0;
			rcv_phase = 0;
		end else begin
			if (seg_ch.valid && rcv_rdy) begin
				got.seg    = seg_ch.segment_valid;
				got.cor[0] = seg_ch.corner0_x;
				got.cor[1] = seg_ch.corner0_y;
				got.cor[2] = seg_ch.corner1_x;
				got.cor[3] = seg_ch.corner1_y;
				got.cor[4] = seg_ch.corner2_x;
				got.cor[5] = seg_ch.corner2_y;
				got.cor[6] = seg_ch.corner3_x;
				got.cor[7] = seg_ch.corner3_y;
				got.act    = seg_ch.pen_active;
				if (stroke_q.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("stroke transfer with nothing expected");
				end else begin
					want = stroke_q.pop_front();
					check_field("segment_valid", OUT_W'(want.seg), OUT_W'(got.seg));
					for (int i = 0; i < 8; i++)
						check_field($sformatf("corner%0d_%s", i / 2, (i % 2 != 0) ? "y" : "x"),
							want.cor[i], got.cor[i]);
					check_field("pen_active", OUT_W'(want.act), OUT_W'(got.act));
				end
			end
			if (rcv_win == 0) begin
				rcv_mode = rx_mode_t'($urandom_range(0, 3));
				rcv_win  = $urandom_range(40, 300);
			end else begin
				rcv_win--;
			end
			rcv_phase++;
			case (rcv_mode)
				RX_OPEN:  nxt_rdy = 1'b1;
				RX_COIN:  nxt_rdy = 1'($urandom_range(0, 1));
				RX_COMB:  nxt_rdy = (rcv_phase % 7) > 2;
				default:  nxt_rdy = ($urandom_range(0, 3) == 0);
			endcase
			if (hold_left != 0)
				nxt_rdy = 1'b0;
			rcv_rdy <= nxt_rdy;
		end
	end

	// stimulus
	function automatic void add_evt(logic [CMD_W-1:0] cmd, logic [OUT_W-1:0] x,
		logic [OUT_W-1:0] y);
		pen_evt_t e;
		e.cmd = cmd;
		e.x   = x;
		e.y   = y;
		event_q.push_back(e);
	endfunction

	function automatic logic [OUT_W-1:0] pick_coord();
		case ($urandom_range(0, 7))
			0:       return 32'h7FFF_FFFF - 32'($urandom_range(0, 32'h000F_FFFF));
			1:       return 32'h8000_0000 + 32'($urandom_range(0, 32'h000F_FFFF));
			2:       return $urandom;
			default: return 32'($urandom_range(0, 32'h0FFF_FFFF)) - 32'h0800_0000;
		endcase
	endfunction

	function automatic logic [OUT_W-1:0] pick_delta();
		if ($urandom_range(0, 15) == 0)
			return $urandom;
		return 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
	endfunction

	task automatic gen_strokes(input int count);
		int               n, len;
		logic [OUT_W-1:0] bx, by;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 9) == 0) begin
				add_evt(CMD_W'($urandom_range(0, 7)), $urandom, $urandom);
				n++;
			end else begin
				bx = pick_coord();
				by = pick_coord();
				add_evt(CMD_DOWN, bx, by);
				len = $urandom_range(1, 24);
				for (int k = 0; k < len; k++) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3: add_evt(CMD_MOVE, bx + pick_delta(), by + pick_delta());
						4, 5, 6:    add_evt(CMD_TICK, $urandom, $urandom);
						default:    add_evt(CMD_EMIT, $urandom, $urandom);
					endcase
				end
				if ($urandom_range(0, 4) != 0)
					add_evt(CMD_UP, $urandom, $urandom);
				n += len + 2;
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_vld <= 1'b1;
		cfg_idx <= idx;
		cfg_dat <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_vld <= 1'b0;
		case (idx)
			CFG_MASS_RECIP:   mass_k = val[K_W-1:0];
			CFG_DAMPING:      damp_k = val[K_W-1:0];
			CFG_STROKE_WIDTH: width_cur = val;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (event_q.size() != 0 || pen_vld || stroke_q.size() != 0);
	endtask

	initial begin
		logic [K_W-1:0] mk_v, dk_v;
		logic [W_W-1:0] wd_v;
		reset_model();
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset register values
		add_evt(CMD_EMIT, 32'h0, 32'h0);
		add_evt(CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_evt(CMD_MOVE, 32'h0010_0000, 32'hFFF0_0000);
		add_evt(CMD_EMIT, 32'h0, 32'h0);
		add_evt(CMD_UP, 32'h0, 32'h0);
		add_evt(CMD_RSVD5, 32'h1234_5678, 32'h8765_4321);
		add_evt(CMD_RSVD6, 32'hFFFF_FFFF, 32'h0);
		add_evt(CMD_RSVD7, 32'h0, 32'hFFFF_FFFF);
		add_evt(CMD_DOWN, 32'h7FFF_FFFF, 32'h8000_0000);
		add_evt(CMD_MOVE, 32'h8000_0000, 32'h7FFF_FFFF);
		add_evt(CMD_TICK, 32'h0, 32'h0);
		add_evt(CMD_TICK, 32'h0, 32'h0);
		add_evt(CMD_TICK, 32'h0, 32'h0);
		add_evt(CMD_EMIT, 32'h0, 32'h0);
		add_evt(CMD_EMIT, 32'h0, 32'h0);
		add_evt(CMD_DOWN, 32'h0, 32'h0);
		add_evt(CMD_MOVE, 32'h0, 32'h0);
		add_evt(CMD_EMIT, 32'h0, 32'h0);
		add_evt(CMD_MOVE, 32'h8000_0000, 32'h8000_0000);
		add_evt(CMD_TICK, 32'h0, 32'h0);
		add_evt(CMD_EMIT, 32'h0, 32'h0);
		add_evt(CMD_UP, 32'h0, 32'h0);
		add_evt(CMD_TICK, 32'h0, 32'h0);
		add_evt(CMD_EMIT, 32'h0, 32'h0);

		for (int p = 0; p < RAND_PHASES; p++) begin
			wait_idle();
			case (p)
				0: begin
					write_reg(CFG_MASS_RECIP, 26'h3FF_FFFF);
					write_reg(CFG_DAMPING, 26'h3FF_FFFF);
					write_reg(CFG_STROKE_WIDTH, 26'h3FF_FFFF);
					write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
				end
				1: begin
					write_reg(CFG_MASS_RECIP, '0);
					write_reg(CFG_DAMPING, '0);
					write_reg(CFG_STROKE_WIDTH, '0);
				end
				default: begin
					case ($urandom_range(0, 5))
						0:       mk_v = '0;
						1:       mk_v = '1;
						2:       mk_v = K_W'($urandom);
						default: mk_v = K_W'($urandom_range(1000, 32'h0020_0000));
					endcase
					case ($urandom_range(0, 5))
						0:       dk_v = '0;
						1:       dk_v = '1;
						2:       dk_v = K_W'($urandom);
						default: dk_v = K_W'($urandom_range(32'h0080_0000, 32'h00FF_FFFF));
					endcase
					case ($urandom_range(0, 5))
						0:       wd_v = '0;
						1:       wd_v = '1;
						2:       wd_v = W_W'($urandom);
						default: wd_v = W_W'($urandom_range(32'h0001_0000, 32'h0014_0000));
					endcase
					write_reg(CFG_MASS_RECIP, {2'($urandom), mk_v});
					write_reg(CFG_DAMPING, {2'($urandom), dk_v});
					write_reg(CFG_STROKE_WIDTH, wd_v);
				end
			endcase
			@(negedge clk);
			gen_strokes(PHASE_ITEMS);
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[pen_mass_drag_stroke_filter] OK");
		else
			$display("[pen_mass_drag_stroke_filter] ERROR");
		$finish;
	end

endmodule
